### design/msm_pkg.sv
// msm_pkg: shared types, constants and arithmetic helpers of the sample mixer
// used by msm_front, msm_back and multichannel_sample_mixer_top
package msm_pkg;

  localparam int DEF_VOICES    = 8;
  localparam int DEF_ADDR_BITS = 16;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  localparam logic [15:0] HANDLE_RESTART = 16'd100;
  localparam logic [8:0]  SEP_SPAN       = 9'd257;
  localparam logic [7:0]  SAMPLE_CENTER  = 8'd128;
  // floor(y / 127) == (y * RECIP_127) >> 22 for y below 33554
  localparam logic [15:0] RECIP_127      = 16'd33027;
  localparam int          RECIP_SHIFT    = 22;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_LOAD  = 2'd2,
    OP_SPARE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DRAIN,
    ST_EXCL,
    ST_FREE,
    ST_GAIN1,
    ST_GAIN2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t          op;
    logic [7:0]   sound_id;
    logic         exclusive;
    logic [6:0]   volume;
    logic [7:0]   separation;
    logic [17:0]  step;
    logic [15:0]  start_addr;
    logic [16:0]  length;
    logic [30:0]  game_tick;
    logic [15:0]  load_addr;
    logic [7:0]   load_byte;
  } cmd_t;

  typedef struct packed {
    logic         kind;
    logic [15:0]  left_sample;
    logic [15:0]  right_sample;
    logic [15:0]  handle;
    logic [2:0]   voice;
  } res_t;

  // gain * |sample - 128| * 256 / 127, truncated; p = gain * |sample - 128|
  // 256 / 127 = 2 + 2 / 127, so the result is 2p + floor(2p / 127)
  function automatic logic [16:0] scale_mag(input logic [14:0] p);
    logic [15:0] y;
    logic [31:0] prod;
    logic [9:0]  q;
    y    = {p, 1'b0};
    prod = 32'(y) * 32'(RECIP_127);
    q    = prod[31:RECIP_SHIFT];
    return 17'(y) + 17'(q);
  endfunction

endpackage

### design/multichannel_sample_mixer_top.sv
// tick: one voice entering the mix pipeline per cycle, then a drain and the emit
// start: the exclusive scan if exclusive, then the free-voice scan, GAIN1, GAIN2 and the emit
// load: stored when taken; one item in service at a time, two more may wait in the input queue
// reset (rst_n low, synchronous) stops all voices and zeroes the handle counter
// sample memory is not cleared; output register holds one waiting word
module multichannel_sample_mixer_top #(
  parameter int VOICES           = msm_pkg::DEF_VOICES,
  parameter int SAMPLE_ADDR_BITS = msm_pkg::DEF_ADDR_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_sound_id,
  input  logic               in_exclusive,
  input  logic [6:0]         in_volume,
  input  logic [7:0]         in_separation,
  input  logic [17:0]        in_step,
  input  logic [15:0]        in_start_addr,
  input  logic [16:0]        in_length,
  input  logic [30:0]        in_game_tick,
  input  logic [15:0]        in_load_addr,
  input  logic [7:0]         in_load_byte,
  output logic               empty,
  input  logic               pop,
  output logic               out_kind,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic [15:0]        out_handle,
  output logic [2:0]         out_voice
);

  msm_pkg::cmd_t in_s;
  msm_pkg::cmd_t head;
  msm_pkg::res_t res;
  msm_pkg::res_t out_r;
  logic          head_vld;
  logic          take;
  logic          res_vld;
  logic          out_vld_r;

  always_comb begin
    in_s.op         = msm_pkg::op_t'(in_cmd);
    in_s.sound_id   = in_sound_id;
    in_s.exclusive  = in_exclusive;
    in_s.volume     = in_volume;
    in_s.separation = in_separation;
    in_s.step       = in_step;
    in_s.start_addr = in_start_addr;
    in_s.length     = in_length;
    in_s.game_tick  = in_game_tick;
    in_s.load_addr  = in_load_addr;
    in_s.load_byte  = in_load_byte;
  end

  msm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_cmd_s (in_s),
    .head_vld (head_vld),
    .head     (head),
    .take     (take)
  );

  msm_back #(
    .VOICES           (VOICES),
    .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (head_vld),
    .cmd      (head),
    .cmd_take (take),
    .out_free (!out_vld_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld) begin
      out_vld_r <= 1'b1;
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_r <= res;
    end
  end

  assign empty            = !out_vld_r;
  assign out_kind         = out_r.kind;
  assign out_left_sample  = out_r.left_sample;
  assign out_right_sample = out_r.right_sample;
  assign out_handle       = out_r.handle;
  assign out_voice        = out_r.voice;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !out_vld_r)
    else $error("result word overwritten before pop");

endmodule

### design/msm_front.sv
// msm_front: input queue of the sample mixer, drops unused command codes
// depends on msm_pkg
module msm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  msm_pkg::cmd_t in_cmd_s,
  output logic          head_vld,
  output msm_pkg::cmd_t head,
  input  logic          take
);

  msm_pkg::cmd_t               q_r [msm_pkg::QDEPTH];
  logic [msm_pkg::QAW-1:0]     wptr_r, wptr_nxt;
  logic [msm_pkg::QAW-1:0]     rptr_r, rptr_nxt;
  logic [msm_pkg::QAW:0]       cnt_r, cnt_nxt;
  logic                        known;
  logic                        wr;
  logic                        rd;

  assign full = (cnt_r == (msm_pkg::QAW+1)'(msm_pkg::QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head = q_r[rptr_r];

  // code 3 is taken off the port and thrown away
  assign known = (in_cmd_s.op == msm_pkg::OP_TICK) || (in_cmd_s.op == msm_pkg::OP_START) ||
                 (in_cmd_s.op == msm_pkg::OP_LOAD);
  assign wr = push && !full && known;
  assign rd = take && head_vld;

  always_comb begin
    wptr_nxt = wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (msm_pkg::QAW+1)'(wr) - (msm_pkg::QAW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wptr_r] <= in_cmd_s;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (msm_pkg::QAW+1)'(msm_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule

### design/msm_back.sv
// msm_back: voice sequencer of the sample mixer: mixing pipeline, voice
// allocation, gain calculation and sample memory; depends on msm_pkg
module msm_back #(
  parameter int VOICES           = msm_pkg::DEF_VOICES,
  parameter int SAMPLE_ADDR_BITS = msm_pkg::DEF_ADDR_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_vld,
  input  msm_pkg::cmd_t cmd,
  output logic          cmd_take,
  input  logic          out_free,
  output logic          res_vld,
  output msm_pkg::res_t res
);

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW    = VW + 1;
  localparam int AB    = SAMPLE_ADDR_BITS;
  localparam int PW    = (AB > 18) ? AB : 18;
  localparam int LW    = (AB > 16) ? AB : 16;
  localparam int DEPTH = 1 << AB;
  localparam int ACC_W = 18 + CW;

  msm_pkg::state_t state_r, state_nxt;
  msm_pkg::cmd_t   cur_r;
  logic [CW-1:0]   cnt_r;
  logic [VW-1:0]   k;
  logic            last;

  // voice state
  logic            va_r    [VOICES];
  logic [17:0]     vpos_r  [VOICES];
  logic [17:0]     vend_r  [VOICES];
  logic [15:0]     vfrac_r [VOICES];
  logic [17:0]     vinc_r  [VOICES];
  logic [30:0]     vtick_r [VOICES];
  logic [7:0]      vsnd_r  [VOICES];
  logic [6:0]      vgl_r   [VOICES];
  logic [6:0]      vgr_r   [VOICES];
  logic [15:0]     hc_r;

  logic [7:0]      mem [DEPTH];
  logic [7:0]      mem_rd_r;
  logic            mem_we;
  logic [PW-1:0]   pos_ext;
  logic [LW-1:0]   ld_ext;

  // control
  logic            issue;
  logic            excl_hit;
  logic            free_hit;
  logic            older;
  logic            fin;

  // mixing pipeline
  logic [18:0]     frac_sum;
  logic            p1_vld_r;
  logic [VW-1:0]   p1_idx_r;
  logic [6:0]      p1_gl_r, p1_gr_r;
  logic [18:0]     p1_sum_r;
  logic [17:0]     p1_pos_r, p1_end_r;
  logic [17:0]     newpos;
  logic            smp_neg;
  logic [7:0]      smp_mag;
  logic            p2_vld_r;
  logic            p2_neg_r;
  logic [14:0]     p2_pl_r, p2_pr_r;
  logic [16:0]     mag_l, mag_r;
  logic            p3_vld_r;
  logic signed [17:0] p3_l_r, p3_r_r;
  logic signed [ACC_W-1:0] accl_r, accr_r;

  // start path
  logic [30:0]     old_tick_r;
  logic [VW-1:0]   old_v_r;
  logic [VW-1:0]   slot_r;
  logic [8:0]      sep_s, sep_r;
  logic [16:0]     sql_r, sqr_r;
  logic [23:0]     tl, tr;
  logic [6:0]      gl_r, gr_r;
  logic [15:0]     h;

  assign k = cnt_r[VW-1:0];
  assign last = (cnt_r == CW'(VOICES - 1));
  assign excl_hit = va_r[k] && (vsnd_r[k] == cur_r.sound_id);
  assign free_hit = !va_r[k];
  assign older = vtick_r[k] < old_tick_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msm_pkg::ST_IDLE: begin
        if (cmd_vld) begin
          unique case (cmd.op)
            msm_pkg::OP_TICK:  state_nxt = msm_pkg::ST_TICK;
            msm_pkg::OP_START: state_nxt = cmd.exclusive ? msm_pkg::ST_EXCL : msm_pkg::ST_FREE;
            default:           state_nxt = msm_pkg::ST_IDLE;
          endcase
        end
      end
      msm_pkg::ST_TICK:  if (last) state_nxt = msm_pkg::ST_DRAIN;
      msm_pkg::ST_DRAIN: if (!(p1_vld_r || p2_vld_r || p3_vld_r)) state_nxt = msm_pkg::ST_EMIT;
      msm_pkg::ST_EXCL:  if (excl_hit || last) state_nxt = msm_pkg::ST_FREE;
      msm_pkg::ST_FREE:  if (free_hit || last) state_nxt = msm_pkg::ST_GAIN1;
      msm_pkg::ST_GAIN1: state_nxt = msm_pkg::ST_GAIN2;
      msm_pkg::ST_GAIN2: state_nxt = msm_pkg::ST_EMIT;
      msm_pkg::ST_EMIT:  if (out_free) state_nxt = msm_pkg::ST_IDLE;
      default:           state_nxt = msm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_take = 1'b0;
    issue    = 1'b0;
    fin      = 1'b0;
    mem_we   = 1'b0;
    unique case (state_r)
      msm_pkg::ST_IDLE: begin
        cmd_take = cmd_vld;
        mem_we   = cmd_vld && (cmd.op == msm_pkg::OP_LOAD);
      end
      msm_pkg::ST_TICK: issue = 1'b1;
      msm_pkg::ST_EMIT: fin = out_free;
      default: ;
    endcase
  end

  assign res_vld = fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == msm_pkg::ST_IDLE ||
        (state_r == msm_pkg::ST_EXCL && state_nxt == msm_pkg::ST_FREE)) begin
      cnt_r <= '0;
    end else if (state_r == msm_pkg::ST_TICK || state_r == msm_pkg::ST_EXCL ||
                 state_r == msm_pkg::ST_FREE) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd_take) begin
      cur_r <= cmd;
    end
  end

  // sample memory
  assign pos_ext = PW'(vpos_r[k]);
  assign ld_ext = LW'(cmd.load_addr);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ld_ext[AB-1:0]] <= cmd.load_byte;
    end
    mem_rd_r <= mem[pos_ext[AB-1:0]];
  end

  // stage 1: position update and sample centering
  assign frac_sum = 19'(vfrac_r[k]) + 19'(vinc_r[k]);
  assign newpos = p1_pos_r + 18'(p1_sum_r[18:16]);
  assign smp_neg = mem_rd_r < msm_pkg::SAMPLE_CENTER;
  assign smp_mag = smp_neg ? 8'(9'(msm_pkg::SAMPLE_CENTER) - 9'(mem_rd_r))
                           : mem_rd_r - msm_pkg::SAMPLE_CENTER;

  // stage 2: scale by 256 / 127
  assign mag_l = msm_pkg::scale_mag(p2_pl_r);
  assign mag_r = msm_pkg::scale_mag(p2_pr_r);

  always_ff @(posedge clk) begin
    p1_idx_r <= k;
    p1_gl_r  <= vgl_r[k];
    p1_gr_r  <= vgr_r[k];
    p1_sum_r <= frac_sum;
    p1_pos_r <= vpos_r[k];
    p1_end_r <= vend_r[k];
    p2_neg_r <= smp_neg;
    p2_pl_r  <= 15'(p1_gl_r) * 15'(smp_mag);
    p2_pr_r  <= 15'(p1_gr_r) * 15'(smp_mag);
    p3_l_r   <= p2_neg_r ? -$signed({1'b0, mag_l}) : $signed({1'b0, mag_l});
    p3_r_r   <= p2_neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= issue && va_r[k];
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == msm_pkg::ST_IDLE) begin
      accl_r <= '0;
      accr_r <= '0;
    end else if (p3_vld_r) begin
      accl_r <= accl_r + ACC_W'(p3_l_r);
      accr_r <= accr_r + ACC_W'(p3_r_r);
    end
  end

  // start: oldest voice search and gains
  assign sep_s = 9'(cur_r.separation) + 9'd1;
  assign sep_r = msm_pkg::SEP_SPAN - sep_s;
  assign tl = 24'(cur_r.volume) * 24'(sql_r);
  assign tr = 24'(cur_r.volume) * 24'(sqr_r);
  assign h = (hc_r == '0) ? msm_pkg::HANDLE_RESTART : hc_r;

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      old_tick_r <= cmd.game_tick;
      old_v_r    <= '0;
    end else if (state_r == msm_pkg::ST_FREE) begin
      if (free_hit) begin
        slot_r <= k;
      end else begin
        if (older) begin
          old_tick_r <= vtick_r[k];
          old_v_r    <= k;
        end
        if (last) begin
          slot_r <= older ? k : old_v_r;
        end
      end
    end
    if (state_r == msm_pkg::ST_GAIN1) begin
      sql_r <= 17'(sep_s) * 17'(sep_s);
      sqr_r <= 17'(sep_r) * 17'(sep_r);
    end
    if (state_r == msm_pkg::ST_GAIN2) begin
      gl_r <= cur_r.volume - 7'(tl[23:16]);
      gr_r <= cur_r.volume - 7'(tr[23:16]);
    end
  end

  // voice registers
  always_ff @(posedge clk) begin
    if (p1_vld_r) begin
      vfrac_r[p1_idx_r] <= p1_sum_r[15:0];
      vpos_r[p1_idx_r]  <= newpos;
    end
    if (fin && cur_r.op == msm_pkg::OP_START) begin
      vpos_r[slot_r]  <= 18'(cur_r.start_addr);
      vend_r[slot_r]  <= 18'(cur_r.start_addr) + 18'(cur_r.length);
      vfrac_r[slot_r] <= '0;
      vinc_r[slot_r]  <= cur_r.step;
      vtick_r[slot_r] <= cur_r.game_tick;
      vsnd_r[slot_r]  <= cur_r.sound_id;
      vgl_r[slot_r]   <= gl_r;
      vgr_r[slot_r]   <= gr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        va_r[i] <= 1'b0;
      end
      hc_r <= '0;
    end else begin
      if (p1_vld_r && newpos >= p1_end_r) begin
        va_r[p1_idx_r] <= 1'b0;
      end
      if (state_r == msm_pkg::ST_EXCL && excl_hit) begin
        va_r[k] <= 1'b0;
      end
      if (fin && cur_r.op == msm_pkg::OP_START) begin
        va_r[slot_r] <= 1'b1;
        hc_r         <= h + 16'd1;
      end
    end
  end

  function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32'sd32767)) begin
      return 16'h7fff;
    end else if (v < -ACC_W'(32'sd32768)) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  always_comb begin
    res = '0;
    if (cur_r.op == msm_pkg::OP_START) begin
      res.kind   = 1'b1;
      res.handle = h;
      res.voice  = 3'(slot_r);
    end else begin
      res.left_sample  = sat16(accl_r);
      res.right_sample = sat16(accr_r);
    end
  end

  a_pipe_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    p3_vld_r |-> (state_r == msm_pkg::ST_TICK || state_r == msm_pkg::ST_DRAIN))
    else $error("mix pipeline busy outside a tick");

  a_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.kind) |-> (res.handle != 16'd0))
    else $error("start acknowledged with handle zero");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msm_pkg::ST_GAIN2) |-> (CW'(slot_r) < CW'(VOICES)))
    else $error("chosen voice out of range");

  a_start_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && cur_r.op == msm_pkg::OP_START) |=> va_r[$past(slot_r)])
    else $error("started voice not active");

endmodule

### tb/tb_multichannel_sample_mixer_top.sv
// testbench for multichannel_sample_mixer_top: directed and random loads, starts and ticks
// checked against an in-bench mixer model; depends on msm_pkg and the top level only
`timescale 1ns / 100ps

module tb_multichannel_sample_mixer_top;

  localparam int NV = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0] in_cmd = '0;
  logic [7:0] in_sound_id = '0;
  logic in_exclusive = 1'b0;
  logic [6:0] in_volume = '0;
  logic [7:0] in_separation = '0;
  logic [17:0] in_step = '0;
  logic [15:0] in_start_addr = '0;
  logic [16:0] in_length = '0;
  logic [30:0] in_game_tick = '0;
  logic [15:0] in_load_addr = '0;
  logic [7:0] in_load_byte = '0;
  logic out_kind;
  logic signed [15:0] out_left_sample, out_right_sample;
  logic [15:0] out_handle;
  logic [2:0] out_voice;

  multichannel_sample_mixer_top dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_cmd(in_cmd), .in_sound_id(in_sound_id), .in_exclusive(in_exclusive),
    .in_volume(in_volume), .in_separation(in_separation), .in_step(in_step),
    .in_start_addr(in_start_addr), .in_length(in_length), .in_game_tick(in_game_tick),
    .in_load_addr(in_load_addr), .in_load_byte(in_load_byte),
    .empty(empty), .pop(pop), .out_kind(out_kind), .out_left_sample(out_left_sample),
    .out_right_sample(out_right_sample), .out_handle(out_handle), .out_voice(out_voice)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mixer model state
  logic [7:0] mem [bit [15:0]];
  bit v_on [NV];
  logic [17:0] v_pos [NV];
  logic [17:0] v_end [NV];
  logic [15:0] v_frac [NV];
  logic [17:0] v_inc [NV];
  logic [30:0] v_tick [NV];
  logic [7:0] v_snd [NV];
  logic [6:0] v_lg [NV];
  logic [6:0] v_rg [NV];
  logic [15:0] next_handle;

  msm_pkg::res_t expected_words [$];
  int mismatches = 0;
  int words_seen = 0;
  int frames_seen = 0;
  int starts_seen = 0;
  bit quiet = 1'b0;
  int cur_tick = 1000;

  function automatic int contrib(logic [6:0] g, logic [7:0] s);
    int p;
    p = int'(g) * (int'(s) - 128) * 256;
    return p / 127;
  endfunction

  function automatic logic [6:0] gain_for(logic [6:0] vol, int s);
    longint sq;
    sq = longint'(s) * s;
    return 7'(vol - ((longint'(vol) * sq) >> 16));
  endfunction

  function automatic logic [15:0] clip16(int x);
    if (x > 32767) return 16'h7fff;
    if (x < -32768) return 16'h8000;
    return 16'(x);
  endfunction

  // predict one accepted word; appends an expected result where one is due
  task automatic mixer_predict(msm_pkg::cmd_t c);
    msm_pkg::res_t r;
    int dl, dr, v, old_v, slot;
    logic [30:0] oldest;
    logic [16:0] f;
    r = '0;
    dl = 0;
    dr = 0;
    if (c.op == msm_pkg::OP_TICK) begin
      for (v = 0; v < NV; v++) begin
        if (v_on[v]) begin
          dl += contrib(v_lg[v], mem[v_pos[v][15:0]]);
          dr += contrib(v_rg[v], mem[v_pos[v][15:0]]);
          f = 17'(v_frac[v]) + 17'(v_inc[v][15:0]);
          v_pos[v] = v_pos[v] + 18'(v_inc[v][17:16]) + 18'(f[16]);
          v_frac[v] = f[15:0];
          if (v_pos[v] >= v_end[v]) v_on[v] = 1'b0;
        end
      end
      r.left_sample = clip16(dl);
      r.right_sample = clip16(dr);
      expected_words.push_back(r);
    end else if (c.op == msm_pkg::OP_START) begin
      if (c.exclusive) begin
        for (v = 0; v < NV; v++) begin
          if (v_on[v] && v_snd[v] == c.sound_id) begin
            v_on[v] = 1'b0;
            break;
          end
        end
      end
      oldest = c.game_tick;
      old_v = 0;
      for (v = 0; v < NV && v_on[v]; v++) begin
        if (v_tick[v] < oldest) begin
          oldest = v_tick[v];
          old_v = v;
        end
      end
      slot = (v == NV) ? old_v : v;
      if (next_handle == 0) next_handle = msm_pkg::HANDLE_RESTART;
      r.kind = 1'b1;
      r.handle = next_handle;
      r.voice = 3'(slot);
      next_handle = next_handle + 16'd1;
      v_on[slot] = 1'b1;
      v_pos[slot] = 18'(c.start_addr);
      v_end[slot] = 18'(c.start_addr) + 18'(c.length);
      v_frac[slot] = '0;
      v_inc[slot] = c.step;
      v_tick[slot] = c.game_tick;
      v_snd[slot] = c.sound_id;
      v_lg[slot] = gain_for(c.volume, int'(c.separation) + 1);
      v_rg[slot] = gain_for(c.volume, int'(c.separation) + 1 - 257);
      expected_words.push_back(r);
    end else if (c.op == msm_pkg::OP_LOAD) begin
      mem[c.load_addr] = c.load_byte;
    end
  endtask

  // send one word, with an optional random gap first
  task automatic send_word(msm_pkg::cmd_t c);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_cmd <= c.op;
    in_sound_id <= c.sound_id;
    in_exclusive <= c.exclusive;
    in_volume <= c.volume;
    in_separation <= c.separation;
    in_step <= c.step;
    in_start_addr <= c.start_addr;
    in_length <= c.length;
    in_game_tick <= c.game_tick;
    in_load_addr <= c.load_addr;
    in_load_byte <= c.load_byte;
    @(posedge clk);
    while (full) @(posedge clk);
    if (c.op != msm_pkg::OP_SPARE) mixer_predict(c);
  endtask

  task automatic idle_push();
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_push();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic msm_pkg::cmd_t mk_load(logic [15:0] a, logic [7:0] b);
    msm_pkg::cmd_t c;
    c = '0;
    c.op = msm_pkg::OP_LOAD;
    c.load_addr = a;
    c.load_byte = b;
    c.sound_id = 8'($urandom);
    c.step = 18'($urandom);
    return c;
  endfunction

  function automatic msm_pkg::cmd_t mk_tick();
    msm_pkg::cmd_t c;
    c = '0;
    c.op = msm_pkg::OP_TICK;
    c.game_tick = 31'($urandom);
    c.load_addr = 16'($urandom);
    return c;
  endfunction

  // starts only touch memory below 256, which the test loads in full
  function automatic msm_pkg::cmd_t mk_start(logic [7:0] sid, bit ex, logic [6:0] vol,
                                             logic [7:0] sep, logic [17:0] stp,
                                             logic [15:0] sa, logic [16:0] len,
                                             logic [30:0] gt);
    msm_pkg::cmd_t c;
    c = '0;
    c.op = msm_pkg::OP_START;
    c.sound_id = sid;
    c.exclusive = ex;
    c.volume = vol;
    c.separation = sep;
    c.step = stp;
    c.start_addr = sa;
    c.length = len;
    c.game_tick = gt;
    return c;
  endfunction

  function automatic msm_pkg::cmd_t rand_start();
    logic [16:0] len;
    logic [15:0] sa;
    len = 17'($urandom_range(0, 100));
    sa = 16'($urandom_range(0, 150));
    cur_tick += $urandom_range(0, 3);
    return mk_start(8'($urandom_range(0, 7)), 1'($urandom), 7'($urandom),
                    8'($urandom), 18'($urandom_range(0, 200000)), sa, len,
                    31'(cur_tick - $urandom_range(0, 20)));
  endfunction

  task automatic test_fill_memory();
    int a;
    for (a = 0; a < 256; a++) begin
      quiet = (a > 40);
      send_word(mk_load(16'(a), (a % 7 == 0) ? 8'd255 : (a % 5 == 0) ? 8'd0 : 8'($urandom)));
    end
    quiet = 1'b0;
    send_word(mk_load(16'hffff, 8'hff));
    send_word(mk_load(16'hfffe, 8'h00));
    wait_drained();
  endtask

  task automatic test_directed();
    msm_pkg::cmd_t c;
    // extremes of volume and panning, zero length, long length, top step
    send_word(mk_start(8'd0, 1'b0, 7'd127, 8'd0, 18'h3ffff, 16'd0, 17'd0, 31'd5));
    send_word(mk_start(8'd255, 1'b0, 7'd127, 8'd255, 18'd1, 16'd7, 17'd65536, 31'd6));
    send_word(mk_start(8'd1, 1'b0, 7'd0, 8'd128, 18'd1, 16'd14, 17'd3, 31'd7));
    send_word(mk_tick());
    send_word(mk_tick());
    // fill every voice so the next start must steal the oldest one
    send_word(mk_start(8'd9, 1'b0, 7'd127, 8'd128, 18'd0, 16'd21, 17'd10, 31'h7fffffff));
    send_word(mk_start(8'd9, 1'b0, 7'd127, 8'd127, 18'd0, 16'd28, 17'd10, 31'd2));
    send_word(mk_start(8'd9, 1'b0, 7'd127, 8'd1, 18'd0, 16'd35, 17'd10, 31'd3));
    send_word(mk_start(8'd9, 1'b0, 7'd127, 8'd200, 18'd0, 16'd42, 17'd10, 31'd1));
    send_word(mk_start(8'd4, 1'b0, 7'd127, 8'd64, 18'd0, 16'd49, 17'd10, 31'd4));
    send_word(mk_start(8'd5, 1'b0, 7'd100, 8'd60, 18'd0, 16'd56, 17'd10, 31'd4));
    send_word(mk_start(8'd6, 1'b0, 7'd50, 8'd30, 18'd0, 16'd63, 17'd10, 31'd4));
    send_word(mk_start(8'd7, 1'b0, 7'd1, 8'd10, 18'd0, 16'd70, 17'd10, 31'd0));
    // no voice older than tick 0, so voice 0 is taken
    send_word(mk_start(8'd8, 1'b0, 7'd127, 8'd128, 18'd0, 16'd77, 17'd10, 31'd0));
    send_word(mk_tick());
    // exclusive start stops the first voice playing sound 9
    send_word(mk_start(8'd9, 1'b1, 7'd127, 8'd128, 18'd0, 16'd84, 17'd10, 31'd9));
    send_word(mk_tick());
    // unused code is dropped
    c = mk_tick();
    c.op = msm_pkg::OP_SPARE;
    send_word(c);
    send_word(mk_tick());
    wait_drained();
  endtask

  task automatic test_handle_run();
    int i;
    // exclusive starts one after another, handles keep counting
    for (i = 0; i < 200; i++) begin
      send_word(mk_start(8'($urandom), 1'b1, 7'($urandom), 8'($urandom),
                         18'd0, 16'($urandom_range(0, 200)), 17'd50, 31'($urandom)));
    end
    wait_drained();
  endtask

  task automatic test_random(int n, bit no_gaps);
    int i, k;
    msm_pkg::cmd_t c;
    quiet = no_gaps;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) c = mk_tick();
      else if (k < 80) c = rand_start();
      else if (k < 97) c = mk_load(16'($urandom_range(0, 255)), 8'($urandom));
      else begin
        c = mk_tick();
        c.op = msm_pkg::OP_SPARE;
      end
      send_word(c);
      // hold off once until the block has answered everything
      if (i == n / 2 && !no_gaps) wait_drained();
    end
    wait_drained();
  endtask

  // result side: random pop stalls, compare against the oldest expectation
  initial begin
    int stall;
    msm_pkg::res_t e;
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 19);
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) begin
        words_seen++;
        if (out_kind) starts_seen++;
        else frames_seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word kind %0d", out_kind);
        end else begin
          e = expected_words.pop_front();
          if (e.kind !== out_kind || e.left_sample !== out_left_sample ||
              e.right_sample !== out_right_sample || e.handle !== out_handle ||
              e.voice !== out_voice) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp k%0d l%0d r%0d h%0d v%0d got k%0d l%0d r%0d h%0d v%0d",
                       e.kind, $signed(e.left_sample), $signed(e.right_sample), e.handle,
                       e.voice, out_kind, out_left_sample, out_right_sample, out_handle,
                       out_voice);
          end
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("multichannel_sample_mixer_top regression: fail");
    $finish;
  end

  initial begin
    int v;
    for (v = 0; v < NV; v++) v_on[v] = 1'b0;
    next_handle = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_memory();
    test_directed();
    test_random(500, 1'b0);
    test_handle_run();
    test_random(400, 1'b0);
    test_random(200, 1'b1);
    if (expected_words.size() != 0) mismatches += expected_words.size();
    $display("covered %0d words: %0d frames and %0d start acks", words_seen, frames_seen,
             starts_seen);
    $display("mix of loads, starts, exclusive stops, voice steals and ticks under stalls");
    if (mismatches == 0) begin
      $display("multichannel_sample_mixer_top regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("multichannel_sample_mixer_top regression: fail");
    end
    $finish;
  end

endmodule
